[design/fsbs_pkg.sv]
// ----------------------------------------------------------------------------
// fsbs_pkg
// Shared types, constants and the control program of the step scheduler.
// ----------------------------------------------------------------------------
package fsbs_pkg;

    // Datapath widths.
    localparam int unsigned TIME_W  = 63;
    localparam int unsigned LAST_W  = 64;
    localparam int unsigned STEP_W  = 32;
    localparam int unsigned POOL_W  = 16;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned S_DATA_W = 128;
    localparam int unsigned M_DATA_W = 80;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned PC_W    = 5;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_FIXED_STEP = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_POOL   = 2'd1;
    localparam logic [IDX_W-1:0] REG_REFILL     = 2'd2;

    // Register reset values.
    localparam logic [STEP_W-1:0] RST_FIXED_STEP = 32'd16666;
    localparam logic [POOL_W-1:0] RST_MAX_POOL   = 16'd32;
    localparam logic [POOL_W-1:0] RST_REFILL     = 16'd4;

    // Input word kinds carried on tuser.
    localparam logic FUNC_QUERY   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // Datapath action of one control word.
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_FIRST,
        ACT_SUB,
        ACT_AMOUNT,
        ACT_DIV_STEP,
        ACT_DIV_POOL,
        ACT_DIV_USED,
        ACT_CAP_COUNT,
        ACT_CAP_USED,
        ACT_EMPTY,
        ACT_POOL,
        ACT_ZERO,
        ACT_ADV,
        ACT_EMIT
    } act_t;

    // Jump condition of one control word; the jump is taken when it holds.
    typedef enum logic [3:0] {
        CND_NEXT,
        CND_JUMP,
        CND_NOT_ACCEPT,
        CND_FUNC,
        CND_NOT_DUE,
        CND_DIV_BUSY,
        CND_CNT_LE_POOL,
        CND_POOL_ZERO,
        CND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        act_t             act;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } uword_t;

    // Status flags that the datapath hands to the sequencer.
    typedef struct packed {
        logic accept;
        logic func;
        logic not_due;
        logic div_busy;
        logic cnt_le_pool;
        logic pool_zero;
        logic out_busy;
    } flags_t;

    // Program addresses.
    localparam logic [PC_W-1:0] A_WAIT      = 5'd0;
    localparam logic [PC_W-1:0] A_KIND      = 5'd1;
    localparam logic [PC_W-1:0] A_FIRST     = 5'd2;
    localparam logic [PC_W-1:0] A_SUB       = 5'd3;
    localparam logic [PC_W-1:0] A_DUE       = 5'd4;
    localparam logic [PC_W-1:0] A_AMOUNT    = 5'd5;
    localparam logic [PC_W-1:0] A_DIV1      = 5'd6;
    localparam logic [PC_W-1:0] A_WAIT1     = 5'd7;
    localparam logic [PC_W-1:0] A_CHK_POOL  = 5'd8;
    localparam logic [PC_W-1:0] A_CHK_ZERO  = 5'd9;
    localparam logic [PC_W-1:0] A_DIV2      = 5'd10;
    localparam logic [PC_W-1:0] A_WAIT2     = 5'd11;
    localparam logic [PC_W-1:0] A_DIV3      = 5'd12;
    localparam logic [PC_W-1:0] A_WAIT3     = 5'd13;
    localparam logic [PC_W-1:0] A_POOL      = 5'd14;
    localparam logic [PC_W-1:0] A_EMIT      = 5'd15;
    localparam logic [PC_W-1:0] A_RETURN    = 5'd16;
    localparam logic [PC_W-1:0] A_EMPTY     = 5'd17;
    localparam logic [PC_W-1:0] A_ADV       = 5'd18;
    localparam logic [PC_W-1:0] A_ZERO      = 5'd19;

    // Control store: one word per program step.
    function automatic uword_t rom_word(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{act: ACT_NONE, cond: CND_JUMP, target: A_WAIT};
        case (pc)
            A_WAIT:     w = '{act: ACT_LOAD,      cond: CND_NOT_ACCEPT,  target: A_WAIT};
            A_KIND:     w = '{act: ACT_NONE,      cond: CND_FUNC,        target: A_ADV};
            A_FIRST:    w = '{act: ACT_FIRST,     cond: CND_NEXT,        target: A_WAIT};
            A_SUB:      w = '{act: ACT_SUB,       cond: CND_NEXT,        target: A_WAIT};
            A_DUE:      w = '{act: ACT_NONE,      cond: CND_NOT_DUE,     target: A_ZERO};
            A_AMOUNT:   w = '{act: ACT_AMOUNT,    cond: CND_NEXT,        target: A_WAIT};
            A_DIV1:     w = '{act: ACT_DIV_STEP,  cond: CND_NEXT,        target: A_WAIT};
            A_WAIT1:    w = '{act: ACT_CAP_COUNT, cond: CND_DIV_BUSY,    target: A_WAIT1};
            A_CHK_POOL: w = '{act: ACT_NONE,      cond: CND_CNT_LE_POOL, target: A_POOL};
            A_CHK_ZERO: w = '{act: ACT_NONE,      cond: CND_POOL_ZERO,   target: A_EMPTY};
            A_DIV2:     w = '{act: ACT_DIV_POOL,  cond: CND_NEXT,        target: A_WAIT};
            A_WAIT2:    w = '{act: ACT_CAP_USED,  cond: CND_DIV_BUSY,    target: A_WAIT2};
            A_DIV3:     w = '{act: ACT_DIV_USED,  cond: CND_NEXT,        target: A_WAIT};
            A_WAIT3:    w = '{act: ACT_CAP_COUNT, cond: CND_DIV_BUSY,    target: A_WAIT3};
            A_POOL:     w = '{act: ACT_POOL,      cond: CND_NEXT,        target: A_WAIT};
            A_EMIT:     w = '{act: ACT_EMIT,      cond: CND_OUT_BUSY,    target: A_EMIT};
            A_RETURN:   w = '{act: ACT_NONE,      cond: CND_JUMP,        target: A_WAIT};
            A_EMPTY:    w = '{act: ACT_EMPTY,     cond: CND_JUMP,        target: A_POOL};
            A_ADV:      w = '{act: ACT_ADV,       cond: CND_JUMP,        target: A_ZERO};
            A_ZERO:     w = '{act: ACT_ZERO,      cond: CND_JUMP,        target: A_EMIT};
            default:    w = '{act: ACT_NONE,      cond: CND_JUMP,        target: A_WAIT};
        endcase
        return w;
    endfunction

endpackage

[design/fsbs_div.sv]
// ----------------------------------------------------------------------------
// fsbs_div
// Serial restoring divider that returns the quotient rounded up.
// ----------------------------------------------------------------------------
module fsbs_div
    import fsbs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [TIME_W-1:0] divisor,
    output logic              done,
    output logic [TIME_W-1:0] quotient
);

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(TIME_W - 1);

    logic [TIME_W-1:0] q_reg, q_next;
    logic [TIME_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              round_reg, round_next;
    logic              done_reg, done_next;
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    always_comb begin
        trial = {rem_reg, q_reg[TIME_W-1]};
        diff  = trial - {1'b0, den_reg};
    end

    // Sequencing of the iterations and the final round-up cycle.
    always_comb begin
        q_next     = q_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        round_next = round_reg;
        done_next  = done_reg;
        if (start) begin
            q_next     = dividend;
            rem_next   = '0;
            cnt_next   = LAST_BIT;
            busy_next  = 1'b1;
            round_next = 1'b0;
            done_next  = 1'b0;
        end else if (busy_reg) begin
            if (!diff[TIME_W]) begin
                rem_next = diff[TIME_W-1:0];
                q_next   = {q_reg[TIME_W-2:0], 1'b1};
            end else begin
                rem_next = trial[TIME_W-1:0];
                q_next   = {q_reg[TIME_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next  = 1'b0;
                round_next = 1'b1;
            end
        end else if (round_reg) begin
            q_next     = q_reg + TIME_W'(rem_reg != '0);
            round_next = 1'b0;
            done_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            round_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            round_reg <= round_next;
            done_reg  <= done_next;
        end
    end

    // Operand and result registers.
    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (start) begin
            den_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[design/fsbs_seq.sv]
// ----------------------------------------------------------------------------
// fsbs_seq
// Step counter and control store that run the scheduler program.
// ----------------------------------------------------------------------------
module fsbs_seq
    import fsbs_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  flags_t flags,
    output act_t   act
);

    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          uw;
    logic            take;

    // Fetch the control word of the current step.
    always_comb begin
        uw = rom_word(pc_reg);
    end

    // Evaluate the jump condition.
    always_comb begin
        case (uw.cond)
            CND_NEXT:        take = 1'b0;
            CND_JUMP:        take = 1'b1;
            CND_NOT_ACCEPT:  take = !flags.accept;
            CND_FUNC:        take = flags.func;
            CND_NOT_DUE:     take = flags.not_due;
            CND_DIV_BUSY:    take = flags.div_busy;
            CND_CNT_LE_POOL: take = flags.cnt_le_pool;
            CND_POOL_ZERO:   take = flags.pool_zero;
            CND_OUT_BUSY:    take = flags.out_busy;
            default:         take = 1'b1;
        endcase
        pc_next = take ? uw.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= A_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign act = uw.act;

endmodule

[design/fixed_step_budget_scheduler.sv]
// ----------------------------------------------------------------------------
// fixed_step_budget_scheduler
// Fixed-timestep scheduler with an iteration pool, run by a microprogram.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Contents
// s_        in   s_tvalid / s_tready    tuser: func; tdata: time_now_us, advance_us
// m_        out  m_tvalid / m_tready    tdata: iterations, step_us
// cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// An advance word and a query that is not due run no division. A due query
// runs one serial division, and a query whose count exceeds a non-empty pool
// runs three of them, all on the shared serial divider.
// Reset is synchronous and active low; no clearing pass is needed.
// A result waits in the output register; the next word is taken meanwhile,
// and its result waits at the emit step until the register is free.
// ----------------------------------------------------------------------------
module fixed_step_budget_scheduler
    import fsbs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input words.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // [62:0] time_now_us, [125:63] advance_us
    input  logic                 s_tuser,   // [0] func
    // Result words.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [15:0] iterations, [78:16] step_us
    // Configuration writes.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    act_t              act;
    flags_t            flags;

    logic [STEP_W-1:0] fixed_step_reg;
    logic [POOL_W-1:0] max_pool_reg;
    logic [POOL_W-1:0] refill_reg;

    logic [LAST_W-1:0] last_reg;
    logic              first_reg;
    logic [POOL_W-1:0] pool_reg;

    logic              func_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] adv_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic              behind_reg;
    logic [TIME_W-1:0] amount_reg;
    logic [TIME_W-1:0] count_reg;
    logic [TIME_W-1:0] used_reg;
    logic [POOL_W-1:0] res_iter_reg;
    logic [TIME_W-1:0] res_step_reg;

    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic              accept;
    logic              out_busy;
    logic [TIME_W-1:0] step_w;
    logic [LAST_W:0]   diff;
    logic [POOL_W:0]   pool_sum;
    logic              div_start;
    logic [TIME_W-1:0] div_b;
    logic              div_done;
    logic [TIME_W-1:0] div_q;

    // Sequencer.
    fsbs_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .act     (act)
    );

    // Shared round-up divider; the dividend is always the amount.
    fsbs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (amount_reg),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // Handshakes.
    assign s_tready  = (act == ACT_LOAD);
    assign accept    = s_tvalid && s_tready;
    assign out_busy  = m_tvalid_reg && !m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // A zero step register acts as a step of one microsecond.
    always_comb begin
        step_w = (fixed_step_reg == '0) ? TIME_W'(1) : TIME_W'(fixed_step_reg);
        diff   = {2'b00, now_reg} - {1'b0, last_reg};
    end

    // Divider operand and start.
    always_comb begin
        div_start = 1'b0;
        div_b     = step_w;
        case (act)
            ACT_DIV_STEP: begin
                div_start = 1'b1;
                div_b     = step_w;
            end
            ACT_DIV_POOL: begin
                div_start = 1'b1;
                div_b     = TIME_W'(pool_reg);
            end
            ACT_DIV_USED: begin
                div_start = 1'b1;
                div_b     = used_reg;
            end
            default: begin
                div_start = 1'b0;
                div_b     = step_w;
            end
        endcase
    end

    // Pool after a due query; the count never exceeds the pool here.
    always_comb begin
        pool_sum = {1'b0, pool_reg} - {1'b0, count_reg[POOL_W-1:0]} + {1'b0, refill_reg};
    end

    // Status flags for the sequencer.
    always_comb begin
        flags.accept      = accept;
        flags.func        = (func_reg == FUNC_ADVANCE);
        flags.not_due     = behind_reg || (elapsed_reg < step_w);
        flags.div_busy    = !div_done;
        flags.cnt_le_pool = (count_reg <= TIME_W'(pool_reg));
        flags.pool_zero   = (pool_reg == '0);
        flags.out_busy    = out_busy;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fixed_step_reg <= RST_FIXED_STEP;
            max_pool_reg   <= RST_MAX_POOL;
            refill_reg     <= RST_REFILL;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FIXED_STEP: fixed_step_reg <= cfg_data;
                REG_MAX_POOL:   max_pool_reg   <= cfg_data[POOL_W-1:0];
                REG_REFILL:     refill_reg     <= cfg_data[POOL_W-1:0];
                default:        ;
            endcase
        end
    end

    // Scheduler state: last update time, first-query mark and pool.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= '0;
            first_reg <= 1'b1;
            pool_reg  <= RST_MAX_POOL;
        end else begin
            case (act)
                ACT_FIRST: begin
                    if (first_reg) begin
                        last_reg  <= {1'b0, now_reg};
                        first_reg <= 1'b0;
                    end
                end
                ACT_ADV: begin
                    last_reg <= last_reg + {1'b0, adv_reg};
                end
                ACT_POOL: begin
                    pool_reg <= (pool_sum < {1'b0, max_pool_reg}) ?
                                pool_sum[POOL_W-1:0] : max_pool_reg;
                end
                default: ;
            endcase
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge aclk) begin
        case (act)
            ACT_LOAD: begin
                if (accept) begin
                    func_reg <= s_tuser;
                    now_reg  <= s_tdata[TIME_W-1:0];
                    adv_reg  <= s_tdata[2*TIME_W-1:TIME_W];
                end
            end
            ACT_SUB: begin
                elapsed_reg <= diff[TIME_W-1:0];
                behind_reg  <= diff[LAST_W];
            end
            ACT_AMOUNT: begin
                amount_reg <= (elapsed_reg > step_w) ? elapsed_reg : step_w;
            end
            ACT_DIV_STEP: begin
                used_reg <= step_w;
            end
            ACT_CAP_COUNT: begin
                if (div_done) begin
                    count_reg <= div_q;
                end
            end
            ACT_CAP_USED: begin
                if (div_done) begin
                    used_reg <= div_q;
                end
            end
            ACT_EMPTY: begin
                count_reg <= '0;
                used_reg  <= '0;
            end
            ACT_POOL: begin
                res_iter_reg <= count_reg[POOL_W-1:0];
                res_step_reg <= used_reg;
            end
            ACT_ZERO: begin
                res_iter_reg <= '0;
                res_step_reg <= '0;
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (act == ACT_EMIT && !out_busy) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (act == ACT_EMIT && !out_busy) begin
            m_tdata_reg <= {1'b0, res_step_reg, res_iter_reg};
        end
    end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed step scheduler. Query and advance words go
// in through the input stream; each accepted word is run through a local
// prediction of the step count, the stretched step and the iteration pool, and
// every result word is compared with the oldest prediction. Directed cases
// come first, then random phases with varied register settings and random
// stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsbs_pkg::*;

    // Index past the last register; writes to it must be ignored.
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [62:0] TIME_MAX    = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam int          IDLE_LIMIT  = 3000;
    localparam int          TAIL_CYCLES = 250;

    typedef struct packed {
        logic [15:0] iterations;
        logic [62:0] step_us;
    } grant_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;  // [62:0] time_now_us, [125:63] advance_us
    logic                s_tuser   = 1'b0; // [0] func
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // [15:0] iterations, [78:16] step_us
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data  = '0;

    // Local copy of the scheduler state and its registers.
    logic [63:0] last_us       = '0;
    logic        first_pending = 1'b1;
    logic [15:0] pool_left     = RST_MAX_POOL;
    logic [31:0] step_reg      = RST_FIXED_STEP;
    logic [15:0] pool_cap      = RST_MAX_POOL;
    logic [15:0] refill_reg    = RST_REFILL;

    grant_t grant_q[$];
    int     errors     = 0;
    int     words_sent = 0;
    int     idle_count = 0;
    int     stall_left = 0;
    bit     gaps_on    = 1'b0;
    bit     stalls_on  = 1'b0;

    fixed_step_budget_scheduler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic [62:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    function automatic logic [63:0] ceil_div(input logic [63:0] num, input logic [63:0] den);
        if (den == 0) begin
            return 64'd0;
        end
        return num / den + ((num % den) != 0 ? 64'd1 : 64'd0);
    endfunction

    // Works out the grant for one word and updates the local state.
    function automatic grant_t schedule_grant(input logic fn, input logic [62:0] now,
                                              input logic [62:0] adv);
        grant_t      g;
        logic [63:0] tick;
        logic [63:0] now64;
        logic [63:0] amount;
        logic [63:0] count;
        logic [63:0] used;
        logic [31:0] refilled;
        g = '0;
        now64 = {1'b0, now};
        if (fn == FUNC_ADVANCE) begin
            last_us = last_us + {1'b0, adv};
        end else begin
            // A zero step register acts as a one microsecond step.
            tick = (step_reg == 0) ? 64'd1 : {32'd0, step_reg};
            if (first_pending) begin
                last_us = now64;
                first_pending = 1'b0;
            end
            // Due only when the last update time is not beyond now.
            if (last_us <= now64 && (now64 - last_us) >= tick) begin
                amount = now64 - last_us;
                if (amount < tick) begin
                    amount = tick;
                end
                count = ceil_div(amount, tick);
                used = tick;
                if (count > {48'd0, pool_left}) begin
                    if (pool_left == 0) begin
                        // Empty pool: nothing runs, but the refill still happens.
                        count = 0;
                        used = 0;
                    end else begin
                        used = ceil_div(amount, {48'd0, pool_left});
                        count = ceil_div(amount, used);
                    end
                end
                refilled = {16'd0, pool_left} - count[31:0] + {16'd0, refill_reg};
                pool_left = (refilled < {16'd0, pool_cap}) ? refilled[15:0] : pool_cap;
                g.iterations = count[15:0];
                g.step_us = used[62:0];
            end
        end
        return g;
    endfunction

    // Sends one word; valid stays high afterwards unless a gap or a drain follows.
    task automatic send_word(input logic fn, input logic [62:0] now, input logic [62:0] adv,
                             output grant_t granted);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {2'b00, adv, now};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        granted = schedule_grant(fn, now, adv);
        grant_q.push_back(granted);
        words_sent++;
    endtask

    task automatic query_at(input logic [63:0] now);
        grant_t g;
        send_word(FUNC_QUERY, now[62:0], rand63(), g);
    endtask

    task automatic advance_by(input logic [62:0] adv);
        grant_t g;
        send_word(FUNC_ADVANCE, rand63(), adv, g);
    endtask

    // Stops sending and waits for every predicted grant to come back.
    task automatic drain_grants();
        s_tvalid <= 1'b0;
        while (grant_q.size() != 0) @(posedge aclk);
    endtask

    // Writes one register; valid is left high for a following write.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_FIXED_STEP: step_reg = val;
            REG_MAX_POOL:   pool_cap = val[15:0];
            REG_REFILL:     refill_reg = val[15:0];
            default: ;
        endcase
    endtask

    // Upper bits of the 16-bit registers carry noise that must be dropped.
    task automatic set_regs(input logic [31:0] tick, input logic [15:0] cap,
                            input logic [15:0] refill);
        drain_grants();
        write_reg(REG_FIXED_STEP, tick);
        write_reg(REG_MAX_POOL, {16'($urandom), cap});
        write_reg(REG_REFILL, {16'($urandom), refill});
        cfg_valid <= 1'b0;
    endtask

    // Reset register values: latch on the first query, one step, then a
    // catch-up that overruns the pool and gets its step stretched.
    task automatic test_reset_defaults();
        query_at(64'd1000);
        query_at(64'd1000 + 64'd16666);
        query_at(64'd1000 + 64'd16666 * 40);
    endtask

    // Last time beyond now, advance by zero and wrap of the last update time.
    task automatic test_advance_wrap();
        advance_by(TIME_MAX);
        query_at(64'd5000);
        advance_by(TIME_MAX);
        advance_by(63'd2);
        advance_by(63'd0);
        query_at(last_us + {32'd0, step_reg});
    endtask

    // Zero step, all-ones step, largest and zero times.
    task automatic test_step_extremes();
        set_regs(32'd0, 16'hFFFF, 16'hFFFF);
        query_at(last_us + 64'd1);
        query_at(last_us + 64'd5);
        set_regs(32'hFFFF_FFFF, 16'd1, 16'd1);
        query_at({1'b0, TIME_MAX});
        query_at(64'd0);
    endtask

    // Zero cap, zero refill and the empty pool on a due query.
    task automatic test_empty_pool();
        set_regs(32'd100, 16'd0, 16'd1);
        query_at(last_us + 64'd100);
        query_at(last_us + 64'd250);
        set_regs(32'd100, 16'd8, 16'd0);
        query_at(last_us + 64'd100);
        set_regs(32'd100, 16'd8, 16'd3);
        query_at(last_us + 64'd100);
        query_at(last_us + 64'd1000);
    endtask

    // A write past the last register must leave all settings alone.
    task automatic test_ignored_index();
        drain_grants();
        write_reg(REG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
        query_at(last_us + 64'd300);
    endtask

    // Mostly frame-like traffic: a query some steps after the last update,
    // then an advance by the granted time; the rest is full-range noise or a wrap.
    task automatic run_traffic_phase(input int stop_at);
        grant_t      g;
        logic [63:0] tick;
        logic [63:0] delta;
        logic [63:0] adv64;
        while (words_sent < stop_at) begin
            tick = (step_reg == 0) ? 64'd1 : {32'd0, step_reg};
            if ($urandom_range(0, 99) < 12) begin
                if ($urandom_range(0, 1) == 1) begin
                    send_word(FUNC_QUERY, rand63(), rand63(), g);
                end else begin
                    send_word(FUNC_ADVANCE, rand63(), rand63(), g);
                end
            end else if (last_us >= 64'h4000_0000_0000_0000) begin
                // Bring the last update time back near zero through the wrap.
                if (last_us > 64'h8000_0000_0000_0000) begin
                    adv64 = 64'd0 - last_us;
                    advance_by(adv64[62:0]);
                end else begin
                    advance_by(TIME_MAX);
                end
            end else begin
                case ($urandom_range(0, 3))
                    0: delta = tick - 64'd1 + 64'($urandom_range(0, 2));
                    1: delta = tick * $urandom_range(1, 4) + 64'($urandom_range(0, 7));
                    2: delta = tick * $urandom_range(1, 3 * pool_cap + 3)
                               + ({32'd0, $urandom} % tick);
                    default: delta = {32'd0, $urandom};
                endcase
                query_at(last_us + delta);
                g = grant_q[$];
                if (g.iterations != 0 && $urandom_range(0, 3) != 0) begin
                    adv64 = {48'd0, g.iterations} * {1'b0, g.step_us};
                    advance_by(adv64[62:0]);
                end
            end
        end
    endtask

    // Random phases, each with its own register setting; the last one runs
    // without gaps or stalls.
    task automatic test_random_traffic();
        logic [31:0] tick;
        logic [15:0] cap;
        logic [15:0] refill;
        for (int ph = 0; ph < 9; ph++) begin
            case ($urandom_range(0, 5))
                0:       tick = 32'd1;
                1:       tick = 32'hFFFF_FFFF;
                2:       tick = $urandom;
                3, 4:    tick = $urandom_range(1, 200);
                default: tick = $urandom_range(1000, 20000);
            endcase
            case ($urandom_range(0, 3))
                0:       cap = 16'd1;
                1:       cap = 16'hFFFF;
                2:       cap = 16'($urandom_range(1, 64));
                default: cap = 16'($urandom_range(0, 16));
            endcase
            case ($urandom_range(0, 3))
                0:       refill = 16'd1;
                1:       refill = 16'hFFFF;
                2:       refill = 16'($urandom_range(0, 8));
                default: refill = 16'($urandom_range(1, 64));
            endcase
            set_regs(tick, cap, refill);
            gaps_on   = (ph < 8) && ($urandom_range(0, 3) != 0);
            stalls_on = (ph < 8) && ($urandom_range(0, 3) != 0);
            run_traffic_phase(words_sent + 100);
        end
    endtask

    // Receiver stalls in random bursts.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(1, 13) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result word with the oldest prediction.
    always @(posedge aclk) begin
        grant_t exp_g;
        if (aresetn && m_tvalid && m_tready) begin
            if (grant_q.size() == 0) begin
                $display("%0t: result word with none expected: iterations %0d step_us %0d",
                         $time, m_tdata[15:0], m_tdata[78:16]);
                errors++;
            end else begin
                exp_g = grant_q.pop_front();
                if (m_tdata[15:0] !== exp_g.iterations) begin
                    $display("%0t: iterations expected %0d, actual %0d",
                             $time, exp_g.iterations, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[78:16] !== exp_g.step_us) begin
                    $display("%0t: step_us expected %0d, actual %0d",
                             $time, exp_g.step_us, m_tdata[78:16]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_reset_defaults();
        test_advance_wrap();
        test_step_extremes();
        test_empty_pool();
        test_ignored_index();
        test_random_traffic();
        drain_grants();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (grant_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, grant_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
